>>> hw/rtl/mqs_pkg.sv
// Shared types and constants of the MQTT session tracker.
// Used by every module of the block; depends on nothing.
package mqs_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_RECV  = 2'd1;
	localparam logic [1:0] FUNC_OFFER = 2'd2;
	localparam logic [1:0] FUNC_POLL  = 2'd3;

	localparam logic [3:0] T_NONE      = 4'd0;
	localparam logic [3:0] T_PUBLISH   = 4'd3;
	localparam logic [3:0] T_PUBACK    = 4'd4;
	localparam logic [3:0] T_PUBREC    = 4'd5;
	localparam logic [3:0] T_PUBREL    = 4'd6;
	localparam logic [3:0] T_PUBCOMP   = 4'd7;
	localparam logic [3:0] T_SUBSCRIBE = 4'd8;
	localparam logic [3:0] T_SUBACK    = 4'd9;
	localparam logic [3:0] T_PINGREQ   = 4'd12;
	localparam logic [3:0] T_PINGRESP  = 4'd13;

	localparam logic [1:0] QOS_ONE = 2'd1;
	localparam logic [1:0] QOS_TWO = 2'd2;

	localparam logic [2:0] EV_NONE       = 3'd0;
	localparam logic [2:0] EV_SUBSCRIBED = 3'd1;
	localparam logic [2:0] EV_SUB_FAILED = 3'd2;
	localparam logic [2:0] EV_PUBLISHED  = 3'd3;
	localparam logic [2:0] EV_DISCONNECT = 3'd4;
	localparam logic [2:0] EV_MSG_RECV   = 3'd5;

	localparam logic [1:0] REG_KEEPALIVE   = 2'd0;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_SEND_GAP    = 2'd2;

	localparam int unsigned MS_PER_S       = 1000;
	localparam logic [25:0] ALIVE_MAX       = 26'h3FF_FFFF;
	localparam logic [15:0] PING_WAIT_MAX   = 16'hFFFF;
	localparam logic [15:0] PING_WAIT_LIMIT = 16'd5000;
	localparam logic [2:0]  PING_LIMIT      = 3'd4;
	localparam logic [7:0]  SUBACK_FAIL     = 8'h80;

	localparam logic [25:0] ALIVE_LIMIT_RST = 26'(60 * MS_PER_S);
	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd3000;
	localparam logic [15:0] SEND_GAP_RST    = 16'd3000;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  pkt_type;
		logic [1:0]  pkt_qos;
		logic [15:0] pkt_id;
		logic [7:0]  last_byte;
		logic        queue_has_room;
	} item_t;

	typedef struct packed {
		logic        tx_accept;
		logic        reply_valid;
		logic [3:0]  reply_type;
		logic [15:0] reply_id;
		logic [2:0]  event_res;
		logic [15:0] event_id;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [25:0] alive_limit;
		logic [15:0] ack_timeout;
		logic [15:0] send_gap;
	} cfg_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r1;
		result_t    r0;
	} push_t;

endpackage

>>> hw/rtl/mqs_core.sv
// Session state and combinational evaluation of one request.
// Depends on mqs_pkg for the request, result and configuration types.
module mqs_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enable,
	input  mqs_pkg::item_t item,
	input  mqs_pkg::cfg_t  cfg,
	output mqs_pkg::push_t push
);

	logic [3:0]  pending_type_q, pending_type_d;
	logic [15:0] pending_id_q, pending_id_d;
	logic [15:0] ack_timer_q, ack_timer_d;
	logic [15:0] send_timer_q, send_timer_d;
	logic [25:0] alive_q, alive_d;
	logic [15:0] ping_wait_q, ping_wait_d;
	logic [2:0]  pings_q, pings_d;
	logic        ping_due_q, ping_due_d;

	always_comb begin
		mqs_pkg::result_t r0;
		mqs_pkg::result_t r1;
		mqs_pkg::result_t ping_a;
		mqs_pkg::result_t ping_b;
		logic [1:0] cnt;
		logic       att1;
		logic       att2;
		logic [2:0] pu_a;
		logic [2:0] pu_b;
		logic [2:0] ev_a;
		logic [2:0] ev_b;

		pending_type_d = pending_type_q;
		pending_id_d   = pending_id_q;
		ack_timer_d    = ack_timer_q;
		send_timer_d   = send_timer_q;
		alive_d        = alive_q;
		ping_wait_d    = ping_wait_q;
		pings_d        = pings_q;
		ping_due_d     = ping_due_q;
		r0             = '0;
		r1             = '0;
		ping_a         = '0;
		ping_b         = '0;
		cnt            = 2'd0;
		att1           = 1'b0;
		att2           = 1'b0;
		pu_a           = pings_q;
		pu_b           = pings_q;
		ev_a           = mqs_pkg::EV_NONE;
		ev_b           = mqs_pkg::EV_NONE;

		unique case (item.func)
			mqs_pkg::FUNC_TICK: begin
				if (ack_timer_q != '0) begin
					ack_timer_d = ack_timer_q - 16'd1;
				end
				if (send_timer_q != '0) begin
					send_timer_d = send_timer_q - 16'd1;
				end
				if (pings_q != '0) begin
					if (ping_wait_q != mqs_pkg::PING_WAIT_MAX) begin
						ping_wait_d = ping_wait_q + 16'd1;
					end
				end else begin
					ping_wait_d = '0;
				end
				if (alive_q != mqs_pkg::ALIVE_MAX) begin
					alive_d = alive_q + 26'd1;
				end
				if (alive_d >= cfg.alive_limit) begin
					ping_due_d = 1'b1;
				end
			end
			mqs_pkg::FUNC_RECV: begin
				r0.last = 1'b1;
				cnt     = 2'd1;
				if (pending_type_q == mqs_pkg::T_SUBSCRIBE) begin
					pings_d     = '0;
					ping_wait_d = '0;
					if (item.pkt_type == mqs_pkg::T_SUBACK) begin
						ack_timer_d = '0;
						r0.event_id = pending_id_q;
						if (item.pkt_id == pending_id_q &&
								item.last_byte != mqs_pkg::SUBACK_FAIL) begin
							pending_type_d = mqs_pkg::T_SUBACK;
							r0.event_res   = mqs_pkg::EV_SUBSCRIBED;
						end else begin
							pending_type_d = mqs_pkg::T_NONE;
							r0.event_res   = mqs_pkg::EV_SUB_FAILED;
						end
					end
				end
				case (item.pkt_type) inside
					mqs_pkg::T_PUBLISH: begin
						pings_d     = '0;
						ping_wait_d = '0;
						if (item.pkt_qos == mqs_pkg::QOS_ONE) begin
							r0.reply_valid = 1'b1;
							r0.reply_type  = mqs_pkg::T_PUBACK;
							r0.reply_id    = item.pkt_id;
						end else if (item.pkt_qos == mqs_pkg::QOS_TWO) begin
							r0.reply_valid = 1'b1;
							r0.reply_type  = mqs_pkg::T_PUBREC;
							r0.reply_id    = item.pkt_id;
						end
						r0.event_res = mqs_pkg::EV_MSG_RECV;
						r0.event_id  = '0;
					end
					mqs_pkg::T_PUBACK, mqs_pkg::T_PUBCOMP: begin
						if (pending_type_q == mqs_pkg::T_PUBLISH &&
								pending_id_q == item.pkt_id) begin
							pending_type_d = mqs_pkg::T_NONE;
							ack_timer_d    = '0;
							r0.event_res   = mqs_pkg::EV_PUBLISHED;
							r0.event_id    = '0;
						end
					end
					mqs_pkg::T_PUBREC: begin
						r0.reply_valid = 1'b1;
						r0.reply_type  = mqs_pkg::T_PUBREL;
						r0.reply_id    = item.pkt_id;
						ack_timer_d    = '0;
					end
					mqs_pkg::T_PUBREL: begin
						r0.reply_valid = 1'b1;
						r0.reply_type  = mqs_pkg::T_PUBCOMP;
						r0.reply_id    = item.pkt_id;
					end
					mqs_pkg::T_PINGRESP: begin
						pings_d     = '0;
						ping_wait_d = '0;
					end
					default: begin
					end
				endcase
			end
			mqs_pkg::FUNC_OFFER: begin
				r0.last = 1'b1;
				cnt     = 2'd1;
				if (ack_timer_q == '0 && send_timer_q == '0) begin
					r0.tx_accept = 1'b1;
					if (item.pkt_type == mqs_pkg::T_SUBSCRIBE) begin
						pending_id_d   = item.pkt_id;
						pending_type_d = mqs_pkg::T_SUBSCRIBE;
						ack_timer_d    = cfg.ack_timeout;
					end else if (item.pkt_type == mqs_pkg::T_PUBLISH) begin
						if (item.pkt_qos == mqs_pkg::QOS_ONE ||
								item.pkt_qos == mqs_pkg::QOS_TWO) begin
							pending_id_d   = item.pkt_id;
							pending_type_d = mqs_pkg::T_PUBLISH;
							ack_timer_d    = cfg.ack_timeout;
						end
					end else if (item.pkt_type == mqs_pkg::T_PUBREL) begin
						ack_timer_d = cfg.ack_timeout;
					end
					send_timer_d = cfg.send_gap;
				end
			end
			mqs_pkg::FUNC_POLL: begin
				att1 = ping_due_q && item.queue_has_room;
				att2 = (ping_wait_q > mqs_pkg::PING_WAIT_LIMIT) && item.queue_has_room;
				if (att1) begin
					pu_a = pings_q + 3'd1;
					if (pu_a >= mqs_pkg::PING_LIMIT) begin
						pu_a = '0;
						ev_a = mqs_pkg::EV_DISCONNECT;
					end
				end
				pu_b = pu_a;
				if (att2) begin
					pu_b = pu_a + 3'd1;
					if (pu_b >= mqs_pkg::PING_LIMIT) begin
						pu_b = '0;
						ev_b = mqs_pkg::EV_DISCONNECT;
					end
				end
				pings_d = pu_b;
				if (att1 || att2) begin
					alive_d    = '0;
					ping_due_d = 1'b0;
				end
				if (ping_wait_q > mqs_pkg::PING_WAIT_LIMIT) begin
					ping_wait_d = '0;
				end
				ping_a.reply_valid = 1'b1;
				ping_a.reply_type  = mqs_pkg::T_PINGREQ;
				ping_a.event_res   = ev_a;
				ping_a.last        = !att2;
				ping_b.reply_valid = 1'b1;
				ping_b.reply_type  = mqs_pkg::T_PINGREQ;
				ping_b.event_res   = ev_b;
				ping_b.last        = 1'b1;
				if (att1) begin
					r0 = ping_a;
					r1 = ping_b;
				end else begin
					r0 = ping_b;
				end
				cnt = {1'b0, att1} + {1'b0, att2};
			end
		endcase

		push.count = enable ? cnt : 2'd0;
		push.r0    = r0;
		push.r1    = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_type_q <= '0;
			pending_id_q   <= '0;
			ack_timer_q    <= '0;
			send_timer_q   <= '0;
			alive_q        <= '0;
			ping_wait_q    <= '0;
			pings_q        <= '0;
			ping_due_q     <= 1'b0;
		end else if (enable) begin
			pending_type_q <= pending_type_d;
			pending_id_q   <= pending_id_d;
			ack_timer_q    <= ack_timer_d;
			send_timer_q   <= send_timer_d;
			alive_q        <= alive_d;
			ping_wait_q    <= ping_wait_d;
			pings_q        <= pings_d;
			ping_due_q     <= ping_due_d;
		end
	end

endmodule

>>> hw/rtl/mqs_fifo.sv
// Four-entry result queue that takes up to two results a cycle.
// Depends on mqs_pkg for the result and push types.
module mqs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  mqs_pkg::push_t   push,
	input  logic             pop,
	output mqs_pkg::result_t head,
	output logic             not_empty,
	output logic [2:0]       level
);

	mqs_pkg::result_t mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] level_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			level_q  <= level_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

endmodule

>>> hw/rtl/mqtt_qos_keepalive_session.sv
// MQTT client session tracker: a request is held in the input register, evaluated by
// the core while the queue has room and its results written to the output queue. A
// request is taken every cycle while the queue has room for two results; results leave
// one per cycle, so output stalls and polls with two pings hold the input off. Reset
// clears all session state and the queue and loads the register defaults. Depends on
// mqs_pkg, mqs_core, mqs_fifo.
module mqtt_qos_keepalive_session (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  mqs_pkg::item_t   cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output mqs_pkg::result_t res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	mqs_pkg::item_t item_s1;
	logic           valid_s1;
	mqs_pkg::cfg_t  cfg_q;
	mqs_pkg::push_t push;
	logic [2:0]     level;
	logic           room2;
	logic           process;
	logic           accept;

	assign cfg_ready = 1'b1;
	assign room2     = (level <= 3'd2);
	assign process   = valid_s1 && room2;
	assign cmd_stall = valid_s1 && !room2;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alive_limit <= mqs_pkg::ALIVE_LIMIT_RST;
			cfg_q.ack_timeout <= mqs_pkg::ACK_TIMEOUT_RST;
			cfg_q.send_gap    <= mqs_pkg::SEND_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mqs_pkg::REG_KEEPALIVE: begin
					cfg_q.alive_limit <= 26'(32'(cfg_data) * 32'(mqs_pkg::MS_PER_S));
				end
				mqs_pkg::REG_ACK_TIMEOUT: begin
					cfg_q.ack_timeout <= cfg_data;
				end
				mqs_pkg::REG_SEND_GAP: begin
					cfg_q.send_gap <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (accept) begin
			item_s1 <= cmd;
		end
	end

	mqs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.enable (process),
		.item   (item_s1),
		.cfg    (cfg_q),
		.push   (push)
	);

	mqs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (res_valid && !res_stall),
		.head      (res),
		.not_empty (res_valid),
		.level     (level)
	);

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("result queue level out of range");

	a_empty_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> room2)
		else $error("empty result queue reports no room");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> valid_s1)
		else $error("accepted request not held in input stage");
`endif

endmodule
